// ===== rtl/crcdd_pkg.sv =====
// Shared types, constants and the byte-wide CRC step for the CRC-32 dedupe filter.
// No dependencies; only the top module imports this package.
package crcdd_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // sequencer states of the lookup engine
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  // reflected CRC-32 over one byte, eight shift/xor steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/crcdd_ifs.sv =====
// Valid/ready channel interfaces: record bytes in, verdicts out.
// Standalone; no package dependency.
interface crcdd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface crcdd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] crc_value;
  logic        already_seen;
  logic        not_stored;

  modport source (output valid, output crc_value, output already_seen, output not_stored,
                  input ready);
  modport sink   (input valid, input crc_value, input already_seen, input not_stored,
                  output ready);
endinterface

// ===== rtl/crcdd_mod.sv =====
// Start-slot unit: reduces the 32-bit hash to a table index, registered on start.
// The table depth is a power of two, so the remainder is the low bits of the hash.
// Depends on nothing but its parameters.
module crcdd_mod #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [31:0]                    value,
  output logic                           done,
  output logic [$clog2(TABLE_DEPTH)-1:0] rem
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // done pulses the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // datapath, no reset needed: mask down to the index bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= value[IDX_W-1:0];
    end
  end

endmodule

// ===== rtl/crcdd_table.sv =====
// Key store of the hash set: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module crcdd_table #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
  input  logic [31:0]                    wdata,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
  output logic [31:0]                    rdata
);

  logic [31:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/crc32_dedupe_filter_top.sv =====
// CRC-32 record fingerprinting with a linear-probing dedupe set.
// Ordinary bytes: one per cycle while the engine is idle; input is held off during a lookup.
// Last byte: hash state, start-slot state, then per probe a table read and a compare (at
// most PROBE_LIMIT probes), then the verdict load, which waits while an earlier verdict is
// pending; input ready again the cycle after the load. After rst the table (TABLE_DEPTH
// entries, a power of two) is swept to zero, input held off. Uses crcdd_* files.
module crc32_dedupe_filter_top #(
  parameter int TABLE_DEPTH = 4096,
  parameter int PROBE_LIMIT = 64
) (
  input  logic               clk,
  input  logic               rst,
  crcdd_in_if.sink           record,
  crcdd_out_if.source        verdict
);

  import crcdd_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int PRB_W = $clog2(PROBE_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [PRB_W-1:0] LAST_PRB  = PRB_W'(PROBE_LIMIT - 1);

  state_t            state, state_next;
  logic [31:0]       crc;
  logic [31:0]       crc_next;
  logic [31:0]       fin_crc;
  logic [31:0]       key;
  logic [IDX_W-1:0]  clr_idx;
  logic [IDX_W-1:0]  slot;
  logic [PRB_W-1:0]  probes;
  logic              res_seen;
  logic              res_ns;

  logic              in_fire;
  logic              out_load;
  logic              hit;
  logic              empty;
  logic              give_up;
  logic [31:0]       hash_val;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic [31:0]       tbl_wdata;
  logic [31:0]       tbl_rdata;

  // handshake and compare terms
  assign in_fire  = record.valid && record.ready;
  assign out_load = (state == ST_DONE) && (!verdict.valid || verdict.ready);
  assign hit      = (tbl_rdata == key);
  assign empty    = (tbl_rdata == 32'd0);
  assign give_up  = (probes == LAST_PRB);
  assign crc_next = crc_byte(crc, record.data_byte);
  assign hash_val = key * HASH_MULT;

  crcdd_mod #(.TABLE_DEPTH(TABLE_DEPTH)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_HASH),
    .value (hash_val),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  crcdd_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (slot),
    .rdata (tbl_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (in_fire && record.last_byte) state_next = ST_HASH;
      ST_HASH:  state_next = ST_MOD;
      ST_MOD:   if (mod_done) state_next = ST_READ;
      ST_READ:  state_next = ST_CMP;
      ST_CMP: begin
        if (hit || empty || give_up) state_next = ST_DONE;
        else                         state_next = ST_READ;
      end
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    record.ready = 1'b0;
    tbl_we       = 1'b0;
    tbl_waddr    = slot;
    tbl_wdata    = key;
    unique case (state)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_idx;
        tbl_wdata = 32'd0;
      end
      ST_IDLE:  record.ready = 1'b1;
      ST_CMP:   tbl_we = !hit && empty;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      crc           <= ALL_ONES;
      verdict.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_idx <= clr_idx + IDX_W'(1);
      if (in_fire) crc <= record.last_byte ? ALL_ONES : crc_next;
      if (out_load)           verdict.valid <= 1'b1;
      else if (verdict.ready) verdict.valid <= 1'b0;
    end
  end

  // record key, probe walk and verdict payload
  always_ff @(posedge clk) begin
    if (in_fire && record.last_byte) begin
      fin_crc <= ~crc_next;
      key     <= (crc_next == ALL_ONES) ? ALL_ONES : ~crc_next;
    end
    if (state == ST_MOD && mod_done) begin
      slot   <= mod_rem;
      probes <= '0;
    end
    if (state == ST_CMP) begin
      res_seen <= hit;
      res_ns   <= !hit && !empty;
      if (!hit && !empty && !give_up) begin
        probes <= probes + PRB_W'(1);
        slot   <= (slot == LAST_IDX) ? '0 : slot + IDX_W'(1);
      end
    end
    if (out_load) begin
      verdict.crc_value    <= fin_crc;
      verdict.already_seen <= res_seen;
      verdict.not_stored   <= res_ns;
    end
  end

  // checks
  a_depth_pow2: assert property (@(posedge clk)
    (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0)
    else $error("table depth is not a power of two");

  a_mod_in_wait: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_MOD)
    else $error("remainder finished outside its wait state");

  a_insert_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && tbl_we) |=> state == ST_DONE)
    else $error("insert did not end the probe walk");

  a_key_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && tbl_we) |-> tbl_wdata != 32'd0)
    else $error("empty marker written as a key");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |-> !(verdict.already_seen && verdict.not_stored))
    else $error("seen and not-stored both set");

endmodule
